FILE: hdl/chdsq_pkg.sv
// Shared types and constants of the chord sequencer sine voice core.
package chdsq_pkg;

   localparam int STEP_W = 32;
   localparam int BEAT_W = 24;
   localparam int AMP_W = 16;
   localparam int CCNT_W = 5;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam int NOTE_W = 9;
   localparam int SIZE_W = 3;
   localparam int RATIO_W = 18;
   localparam int PROD_W = STEP_W + RATIO_W;
   localparam int ACC_W = 20;
   localparam int VOICE_W = 4 * 32;

   localparam longint HALF_PI_Q30 = 64'd1686629713;

   localparam logic [RATIO_W-1:0] SEMI_RATIO [16] = '{
      18'd65536, 18'd69433, 18'd73562, 18'd77936, 18'd82570, 18'd87480, 18'd92682,
      18'd98193, 18'd104032, 18'd110218, 18'd116772, 18'd123715, 18'd131072,
      18'd138866, 18'd147124, 18'd155872
   };

   typedef enum logic [1:0] {
      REQ_TICK  = 2'd0,
      REQ_WRITE = 2'd1,
      REQ_START = 2'd2,
      REQ_NONE  = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      CSR_STEP_A4 = 2'd0,
      CSR_BEAT    = 2'd1,
      CSR_MASTER  = 2'd2,
      CSR_CHORDS  = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SIZE,
      ST_LVL_GO,
      ST_LVL_WAIT,
      ST_FADE_GO,
      ST_FADE_WAIT,
      ST_NOTE_RD,
      ST_NOTE_MUL,
      ST_NOTE_WR,
      ST_MIX_GO,
      ST_MIX_RD,
      ST_MIX_SIN,
      ST_MIX_MUL,
      ST_MIX_ACC,
      ST_OUT
   } state_type;

endpackage

FILE: hdl/chdsq_if.sv
// Request and response channel interfaces of the chord sequencer.
interface chdsq_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] req_type;
   logic [3:0] chord_slot;
   logic [1:0] voice_slot;
   logic [3:0] semitone;
   logic [3:0] octave;
   logic       decays;
   logic       last_note;

   modport source (output valid, req_type, chord_slot, voice_slot, semitone, octave, decays,
                   last_note, input ready);
   modport sink (input valid, req_type, chord_slot, voice_slot, semitone, octave, decays,
                 last_note, output ready);
endinterface

interface chdsq_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] sample;
   logic               finished;

   modport source (output valid, sample, finished, input ready);
   modport sink (input valid, sample, finished, output ready);
endinterface

FILE: hdl/chdsq_div.sv
// Restoring divider, one quotient bit per cycle.
module chdsq_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [23:0] divisor,
   output logic        done,
   output logic [31:0] quotient
);
   logic [24:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [23:0] dvs_ff;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [24:0] trial;

   always_comb begin
      trial = {rem_ff[23:0], quo_ff[31]};
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = trial - {1'b0, dvs_ff};
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) dvs_ff <= divisor;
   end

   assign done = done_ff;
   assign quotient = quo_ff;
endmodule

FILE: hdl/chord_sequencer_sine_voices_core.sv
// Chord sequencer that mixes sine voices from a note table, one sample per tick.
// Channels: req_ch takes items (tick, note write, start), rsp_ch returns one
// result per item with the mixed sample and the finished flag. The csr port
// writes phase step for A4, samples per beat, master amplitude and chord count.
// Work per item: a note write goes straight to the output; a tick inside a
// chord steps each active voice through read, sine, multiply and accumulate;
// a start, or a tick that opens a new chord, first loads the chord with two
// passes of the shared divider (level and fade) and the per-voice step multiply.
// Voice state lives in a one-port voice memory read and rewritten per voice,
// and the sine comes from a ROM with a registered read.
// One item is in work at a time; the next is taken once the result sits in
// the output register, which holds it while the receiver stalls.
// Reset clears control state and the registers to their defaults; playback
// is stopped, so ticks report finished until a start item arrives.
module chord_sequencer_sine_voices_core #(
   parameter int MAX_CHORDS = 16,
   parameter int MAX_VOICES = 4,
   parameter int SINE_TABLE_DEPTH = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   chdsq_req_if.sink                    req_ch,
   chdsq_rsp_if.source                  rsp_ch,
   input  logic                         csr_we,
   input  logic [chdsq_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [chdsq_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import chdsq_pkg::*;

   localparam int CW = (MAX_CHORDS > 1) ? $clog2(MAX_CHORDS) : 1;
   localparam int CNW = $clog2(MAX_CHORDS + 1);
   localparam int VW = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
   localparam int NE = MAX_CHORDS * MAX_VOICES;
   localparam int NAW = (NE > 1) ? $clog2(NE) : 1;
   localparam int SW = $clog2(SINE_TABLE_DEPTH);

   function automatic logic signed [15:0] sine_entry(input int k);
      longint u, x, x2, term, sum;
      logic neg;
      u = 4 * longint'(k);
      neg = 1'b0;
      if (u >= 2 * SINE_TABLE_DEPTH) begin
         u = u - 2 * SINE_TABLE_DEPTH;
         neg = 1'b1;
      end
      if (u > SINE_TABLE_DEPTH) u = 2 * SINE_TABLE_DEPTH - u;
      x = (u * HALF_PI_Q30) / SINE_TABLE_DEPTH;
      x2 = (x * x) >>> 30;
      term = ((x * x2) >>> 30) / 6;
      sum = x - term;
      term = ((term * x2) >>> 30) / 20;
      sum = sum + term;
      term = ((term * x2) >>> 30) / 42;
      sum = sum - term;
      term = ((term * x2) >>> 30) / 72;
      sum = sum + term;
      term = ((term * x2) >>> 30) / 110;
      sum = sum - term;
      if (sum < 0) sum = 0;
      sum = (sum + 16384) >>> 15;
      if (sum > 32767) sum = 32767;
      return neg ? -16'(sum) : 16'(sum);
   endfunction

   // configuration
   logic [STEP_W-1:0] step_a4_ff;
   logic [BEAT_W-1:0] beat_len_ff;
   logic [AMP_W-1:0]  master_ff;
   logic [CCNT_W-1:0] chords_ff;
   logic [BEAT_W-1:0] eff_beat;
   logic [CNW-1:0]    eff_count;

   // control and datapath
   state_type          state_ff, state_in;
   logic [CNW-1:0]     cur_ff, cur_in;
   logic [BEAT_W-1:0]  beat_ff, beat_in;
   logic               run_ff, run_in;
   logic [SIZE_W-1:0]  vcount_ff, vcount_in;
   logic [VW-1:0]      vidx_ff, vidx_in;
   logic               start_ff, start_in;
   logic               fin_ff, fin_in;
   logic [31:0]        level_ff, level_in;
   logic [31:0]        fade_ff, fade_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [4:0]         sh_ff, sh_in;
   logic               dec_ff, dec_in;
   logic [46:0]        mul_ff, mul_in;
   logic               neg_ff, neg_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] rsp_sample_ff, rsp_sample_in;
   logic               rsp_fin_ff, rsp_fin_in;

   // memories
   logic [NOTE_W-1:0]  note_mem [NE];
   logic [SIZE_W-1:0]  size_mem [MAX_CHORDS];
   logic [VOICE_W-1:0] voice_mem [MAX_VOICES];
   logic signed [15:0] sine_rom [SINE_TABLE_DEPTH];
   logic [NOTE_W-1:0]  note_rd_ff;
   logic [SIZE_W-1:0]  size_rd_ff;
   logic [VOICE_W-1:0] voice_rd_ff;
   logic signed [15:0] sine_rd_ff;

   logic               note_we, size_we, voice_we;
   logic [NAW-1:0]     note_waddr, note_raddr;
   logic [CW-1:0]      size_waddr;
   logic [VOICE_W-1:0] voice_wdata;
   logic [SW-1:0]      sine_addr;

   logic               div_start, div_done;
   logic [31:0]        div_dividend, div_q;
   logic [23:0]        div_divisor;

   logic               accept, wr_ok, out_free;
   logic [SIZE_W-1:0]  cnt_clamp;
   logic [PROD_W:0]    rounded;
   logic [31:0]        v_phase, v_step, v_level, v_fade;
   logic [15:0]        mag;

   for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_sine
      assign sine_rom[k] = sine_entry(k);
   end

   chdsq_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      eff_beat = (beat_len_ff == '0) ? BEAT_W'(1) : beat_len_ff;
      if (chords_ff == '0) eff_count = CNW'(1);
      else if (32'(chords_ff) > 32'(MAX_CHORDS)) eff_count = CNW'(MAX_CHORDS);
      else eff_count = CNW'(chords_ff);
   end

   assign accept = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign wr_ok = (32'(req_ch.chord_slot) < 32'(MAX_CHORDS))
                  && (32'(req_ch.voice_slot) < 32'(MAX_VOICES));
   assign {v_phase, v_step, v_level, v_fade} = voice_rd_ff;
   assign cnt_clamp = (32'(size_rd_ff) > 32'(MAX_VOICES)) ? SIZE_W'(MAX_VOICES) : size_rd_ff;
   assign rounded = {1'b0, prod_ff} + ((PROD_W + 1)'(1) << (sh_ff - 5'd1));
   assign mag = sine_rd_ff[15] ? 16'(-sine_rd_ff) : 16'(sine_rd_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_ch.req_type == REQ_START) state_in = ST_SIZE;
               else if (req_ch.req_type == REQ_TICK) begin
                  if (!run_ff) state_in = ST_OUT;
                  else if (beat_ff != '0) state_in = ST_MIX_GO;
                  else if (32'(cur_ff) + 1 >= 32'(eff_count)) state_in = ST_OUT;
                  else state_in = ST_SIZE;
               end else state_in = ST_OUT;
            end
         end
         ST_SIZE:      state_in = ST_LVL_GO;
         ST_LVL_GO:    state_in = ST_LVL_WAIT;
         ST_LVL_WAIT:  if (div_done) state_in = ST_FADE_GO;
         ST_FADE_GO:   state_in = ST_FADE_WAIT;
         ST_FADE_WAIT: if (div_done) state_in = ST_NOTE_RD;
         ST_NOTE_RD:   state_in = ST_NOTE_MUL;
         ST_NOTE_MUL:  state_in = ST_NOTE_WR;
         ST_NOTE_WR: begin
            if (32'(vidx_ff) + 1 < 32'(MAX_VOICES)) state_in = ST_NOTE_RD;
            else if (start_ff) state_in = ST_OUT;
            else state_in = ST_MIX_GO;
         end
         ST_MIX_GO:    state_in = (vcount_ff == '0) ? ST_OUT : ST_MIX_RD;
         ST_MIX_RD:    state_in = ST_MIX_SIN;
         ST_MIX_SIN:   state_in = ST_MIX_MUL;
         ST_MIX_MUL:   state_in = ST_MIX_ACC;
         ST_MIX_ACC:   state_in = (32'(vidx_ff) + 1 >= 32'(vcount_ff)) ? ST_OUT : ST_MIX_RD;
         ST_OUT:       if (out_free) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      cur_in = cur_ff;
      beat_in = beat_ff;
      run_in = run_ff;
      vcount_in = vcount_ff;
      vidx_in = vidx_ff;
      start_in = start_ff;
      fin_in = fin_ff;
      level_in = level_ff;
      fade_in = fade_ff;
      prod_in = prod_ff;
      sh_in = sh_ff;
      dec_in = dec_ff;
      mul_in = mul_ff;
      neg_in = neg_ff;
      acc_in = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_sample_in = rsp_sample_ff;
      rsp_fin_in = rsp_fin_ff;
      note_we = 1'b0;
      size_we = 1'b0;
      voice_we = 1'b0;
      note_waddr = NAW'(32'(req_ch.chord_slot) * MAX_VOICES + 32'(req_ch.voice_slot));
      size_waddr = CW'(req_ch.chord_slot);
      note_raddr = NAW'(32'(cur_ff) * MAX_VOICES + 32'(vidx_ff));
      voice_wdata = '0;
      sine_addr = v_phase[31 -: SW];
      div_start = 1'b0;
      div_dividend = {master_ff, 16'd0};
      div_divisor = {21'd0, cnt_clamp};
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               acc_in = '0;
               vidx_in = '0;
               fin_in = !run_ff;
               start_in = 1'b0;
               unique case (req_ch.req_type)
                  REQ_WRITE: begin
                     note_we = wr_ok;
                     size_we = wr_ok && req_ch.last_note;
                  end
                  REQ_START: begin
                     cur_in = '0;
                     beat_in = eff_beat;
                     run_in = 1'b1;
                     start_in = 1'b1;
                     fin_in = 1'b0;
                  end
                  REQ_TICK: begin
                     if (run_ff && beat_ff == '0) begin
                        if (32'(cur_ff) + 1 >= 32'(eff_count)) begin
                           run_in = 1'b0;
                           fin_in = 1'b1;
                        end else begin
                           cur_in = cur_ff + CNW'(1);
                           beat_in = eff_beat;
                           fin_in = 1'b0;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_LVL_GO: begin
            vcount_in = cnt_clamp;
            div_start = (cnt_clamp != '0);
         end
         ST_LVL_WAIT: begin
            if (div_done) level_in = (vcount_ff == '0) ? 32'd0 : div_q;
         end
         ST_FADE_GO: begin
            div_start = 1'b1;
            div_dividend = level_ff;
            div_divisor = eff_beat;
         end
         ST_FADE_WAIT: begin
            if (div_done) fade_in = div_q;
         end
         ST_NOTE_MUL: begin
            prod_in = PROD_W'(step_a4_ff * SEMI_RATIO[note_rd_ff[3:0]]);
            sh_in = ((note_rd_ff[3:0] < 4'd3) ? 5'd20 : 5'd21) - {1'b0, note_rd_ff[7:4]};
            dec_in = note_rd_ff[8];
         end
         ST_NOTE_WR: begin
            voice_we = 1'b1;
            voice_wdata = {32'd0, 32'(rounded >> sh_ff), level_ff, dec_ff ? fade_ff : 32'd0};
            vidx_in = vidx_ff + VW'(1);
            if (32'(vidx_ff) + 1 >= 32'(MAX_VOICES)) vidx_in = '0;
         end
         ST_MIX_GO: begin
            beat_in = beat_ff - BEAT_W'(1);
            vidx_in = '0;
         end
         ST_MIX_MUL: begin
            mul_in = 47'(mag[14:0] * v_level);
            neg_in = sine_rd_ff[15];
            voice_we = 1'b1;
            voice_wdata = {v_phase + v_step, v_step,
                           (v_level > v_fade) ? v_level - v_fade : 32'd0, v_fade};
         end
         ST_MIX_ACC: begin
            acc_in = neg_ff ? acc_ff - ACC_W'(mul_ff[46:32]) : acc_ff + ACC_W'(mul_ff[46:32]);
            vidx_in = vidx_ff + VW'(1);
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_fin_in = fin_ff;
               if (acc_ff > ACC_W'(32767)) rsp_sample_in = 16'sd32767;
               else if (acc_ff < -ACC_W'(32768)) rsp_sample_in = -16'sd32768;
               else rsp_sample_in = 16'(acc_ff);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_a4_ff <= 32'd39370534;
         beat_len_ff <= 24'd48000;
         master_ff <= 16'd19661;
         chords_ff <= 5'd1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_STEP_A4: step_a4_ff <= csr_wdata;
            CSR_BEAT:    beat_len_ff <= csr_wdata[BEAT_W-1:0];
            CSR_MASTER:  master_ff <= csr_wdata[AMP_W-1:0];
            CSR_CHORDS:  chords_ff <= csr_wdata[CCNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cur_ff <= '0;
         beat_ff <= '0;
         run_ff <= 1'b0;
         vcount_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cur_ff <= cur_in;
         beat_ff <= beat_in;
         run_ff <= run_in;
         vcount_ff <= vcount_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      vidx_ff <= vidx_in;
      start_ff <= start_in;
      fin_ff <= fin_in;
      level_ff <= level_in;
      fade_ff <= fade_in;
      prod_ff <= prod_in;
      sh_ff <= sh_in;
      dec_ff <= dec_in;
      mul_ff <= mul_in;
      neg_ff <= neg_in;
      acc_ff <= acc_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_fin_ff <= rsp_fin_in;
   end

   always_ff @(posedge clock) begin
      if (note_we) note_mem[note_waddr] <= {req_ch.decays, req_ch.octave, req_ch.semitone};
      note_rd_ff <= note_mem[note_raddr];
   end

   always_ff @(posedge clock) begin
      if (size_we) size_mem[size_waddr] <= SIZE_W'({1'b0, req_ch.voice_slot} + 3'd1);
      size_rd_ff <= size_mem[cur_ff[CW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (voice_we) voice_mem[vidx_ff] <= voice_wdata;
      voice_rd_ff <= voice_mem[vidx_ff];
   end

   always_ff @(posedge clock) begin
      sine_rd_ff <= sine_rom[sine_addr];
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.sample = rsp_sample_ff;
   assign rsp_ch.finished = rsp_fin_ff;
endmodule

FILE: verif/chord_sequencer_sine_voices_core_tb.sv
// Self-checking testbench of the chord sequencer sine voice core.
`timescale 1ns / 100ps

module chord_sequencer_sine_voices_core_tb;
   import chdsq_pkg::*;

   localparam int ITEM_TARGET = 1150;
   localparam int IDLE_LIMIT = 20000;
   localparam int SETTLE_CYCLES = 200;

   typedef struct packed {
      req_kind_type kind;
      logic [3:0]   chord_slot;
      logic [1:0]   voice_slot;
      logic [3:0]   semitone;
      logic [3:0]   octave;
      logic         decays;
      logic         last_note;
   } note_req_t;

   typedef struct packed {
      logic signed [15:0] sample;
      logic               finished;
   } mix_out_t;

   typedef struct {
      note_req_t item;
      bit        typed;
      mix_out_t  value;
   } script_row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   chdsq_req_if req_ch ();
   chdsq_rsp_if rsp_ch ();

   chord_sequencer_sine_voices_core uut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   // predictor state
   logic [31:0] step_a4;
   logic [23:0] beat_len;
   logic [15:0] master_amp;
   logic [4:0]  chord_total;
   logic [8:0]  notes [64];
   logic [2:0]  sizes [16];
   logic [3:0]  chord_now;
   logic [23:0] beat_left;
   bit          playing;
   int unsigned active_voices;
   logic [31:0] v_phase [4];
   logic [31:0] v_step [4];
   logic [31:0] v_level [4];
   logic [31:0] v_fade [4];
   int          sine_q15 [1024];

   logic [17:0] ratio_q16 [16] = '{
      18'd65536, 18'd69433, 18'd73562, 18'd77936, 18'd82570, 18'd87480,
      18'd92682, 18'd98193, 18'd104032, 18'd110218, 18'd116772, 18'd123715,
      18'd131072, 18'd138866, 18'd147124, 18'd155872
   };

   mix_out_t    pending_mix [$];
   int          mismatches = 0;
   int          items_sent = 0;
   int          results_seen = 0;
   int          ticks_sent = 0;
   int          nonzero_samples = 0;
   int          idle_cycles = 0;
   bit          quiet = 1'b0;
   script_row_t script [$];

   function automatic int sine_value(int k);
      longint unsigned u;
      bit neg;
      longint x, x2, term, acc;
      int i;
      u = longint'(4 * k);
      neg = 1'b0;
      if (u >= 2048) begin
         u -= 2048;
         neg = 1'b1;
      end
      if (u > 1024) u = 2048 - u;
      x = longint'((u * 64'd1686629713) / 1024);
      x2 = (x * x) >>> 30;
      term = x;
      acc = x;
      for (i = 1; i <= 5; i++) begin
         term = ((term * x2) >>> 30) / longint'((2 * i) * (2 * i + 1));
         if (i & 1) acc -= term;
         else acc += term;
      end
      if (acc < 0) acc = 0;
      acc = (acc + (64'sd1 <<< 14)) >>> 15;
      if (acc > 32767) acc = 32767;
      return neg ? -int'(acc) : int'(acc);
   endfunction

   function automatic logic [31:0] pitch_step(logic [3:0] semi, logic [3:0] oct);
      int e, sh;
      longint unsigned prod;
      e = int'(oct) - (semi < 3 ? 4 : 5);
      sh = 16 - e;
      prod = longint'(step_a4) * longint'(ratio_q16[semi]);
      return 32'((prod + (64'd1 << (sh - 1))) >> sh);
   endfunction

   function automatic int unsigned beat_eff();
      return beat_len == 0 ? 1 : 32'(beat_len);
   endfunction

   function automatic int unsigned chords_eff();
      if (chord_total == 0) return 1;
      if (chord_total > 16) return 16;
      return 32'(chord_total);
   endfunction

   function automatic void open_chord();
      int unsigned cnt;
      logic [31:0] lvl;
      logic [8:0] nt;
      cnt = 32'(sizes[chord_now]);
      if (cnt > 4) cnt = 4;
      active_voices = cnt;
      lvl = cnt != 0 ? 32'((longint'(master_amp) << 16) / cnt) : 32'd0;
      for (int v = 0; v < 4; v++) begin
         nt = notes[chord_now * 4 + v];
         v_phase[v] = '0;
         v_step[v] = pitch_step(nt[3:0], nt[7:4]);
         v_level[v] = lvl;
         v_fade[v] = nt[8] ? lvl / beat_eff() : 32'd0;
      end
   endfunction

   function automatic mix_out_t mix_predict(note_req_t it);
      mix_out_t r;
      longint acc, part;
      int s;
      longint unsigned mag;
      r.sample = '0;
      r.finished = !playing;
      case (it.kind)
         REQ_WRITE: begin
            notes[it.chord_slot * 4 + it.voice_slot] = {it.decays, it.octave, it.semitone};
            if (it.last_note) sizes[it.chord_slot] = it.voice_slot + 3'd1;
         end
         REQ_START: begin
            chord_now = '0;
            beat_left = 24'(beat_eff());
            playing = 1'b1;
            open_chord();
            r.finished = 1'b0;
         end
         REQ_TICK: begin
            if (playing && beat_left == 0) begin
               if (chord_now + 1 >= chords_eff()) playing = 1'b0;
               else begin
                  chord_now++;
                  beat_left = 24'(beat_eff());
                  open_chord();
               end
            end
            r.finished = !playing;
            if (playing) begin
               acc = 0;
               beat_left--;
               for (int v = 0; v < active_voices; v++) begin
                  s = sine_q15[v_phase[v][31:22]];
                  mag = longint'(s < 0 ? -s : s);
                  part = longint'((mag * longint'(v_level[v])) >> 32);
                  acc += s < 0 ? -part : part;
                  v_phase[v] += v_step[v];
                  v_level[v] = v_level[v] > v_fade[v] ? v_level[v] - v_fade[v] : 32'd0;
               end
               if (acc > 32767) acc = 32767;
               if (acc < -32768) acc = -32768;
               r.sample = 16'(acc);
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      mismatches++;
      $display("MISMATCH %s: got %0d, expected %0d (result %0d)", what, got, want,
               results_seen);
   endtask

   // hold valid across back-to-back transfers; drop it only on a gap
   task automatic send_item(note_req_t it, bit typed = 1'b0, mix_out_t value = '0);
      int gap;
      mix_out_t p;
      gap = quiet ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.req_type <= it.kind;
      req_ch.chord_slot <= it.chord_slot;
      req_ch.voice_slot <= it.voice_slot;
      req_ch.semitone <= it.semitone;
      req_ch.octave <= it.octave;
      req_ch.decays <= it.decays;
      req_ch.last_note <= it.last_note;
      do @(negedge clock); while (!req_ch.ready);
      @(posedge clock);
      p = mix_predict(it);
      pending_mix.push_back(typed ? value : p);
      items_sent++;
      if (it.kind == REQ_TICK) ticks_sent++;
   endtask

   task automatic csr_write(csr_index_type idx, logic [31:0] data);
      req_ch.valid <= 1'b0;
      while (pending_mix.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_STEP_A4: step_a4 = data;
         CSR_BEAT:    beat_len = data[23:0];
         CSR_MASTER:  master_amp = data[15:0];
         default:     chord_total = data[4:0];
      endcase
   endtask

   function automatic note_req_t make_req(req_kind_type k, int cs = 0, int vs = 0,
                                          int semi = 0, int oct = 0, bit dec = 0,
                                          bit last = 0);
      note_req_t it;
      it.kind = k;
      it.chord_slot = 4'(cs);
      it.voice_slot = 2'(vs);
      it.semitone = 4'(semi);
      it.octave = 4'(oct);
      it.decays = dec;
      it.last_note = last;
      return it;
   endfunction

   function automatic note_req_t random_note(int cs, int vs);
      return make_req(REQ_WRITE, cs, vs, $urandom_range(0, 15), $urandom_range(0, 15),
                      $urandom_range(0, 1), $urandom_range(0, 1));
   endfunction

   function automatic void add_row(note_req_t it, bit typed = 0, int smp = 0, bit fin = 0);
      script_row_t row;
      row.item = it;
      row.typed = typed;
      row.value.sample = 16'(smp);
      row.value.finished = fin;
      script.push_back(row);
   endfunction

   always @(negedge clock) begin
      mix_out_t want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         results_seen++;
         if (pending_mix.size() == 0) begin
            mismatches++;
            $display("MISMATCH: result %0d arrived with none outstanding", results_seen);
         end else begin
            want = pending_mix.pop_front();
            if (rsp_ch.sample !== want.sample)
               report_mismatch("sample", int'(rsp_ch.sample), int'(want.sample));
            if (rsp_ch.finished !== want.finished)
               report_mismatch("finished", int'(rsp_ch.finished), int'(want.finished));
            if (rsp_ch.sample != 0) nonzero_samples++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no transfer in %0d cycles", IDLE_LIMIT);
         $display("chord_sequencer_sine_voices_core_tb: done, errors");
         $finish;
      end
   end

   initial begin
      int stall;
      rsp_ch.ready <= 1'b0;
      @(negedge reset);
      forever begin
         stall = quiet ? 0 : $urandom_range(0, 11);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(negedge clock); while (!rsp_ch.valid);
         @(posedge clock);
      end
   end

   initial begin
      int n_ticks, pick;
      req_ch.valid <= 1'b0;
      req_ch.req_type <= REQ_TICK;
      req_ch.chord_slot <= '0;
      req_ch.voice_slot <= '0;
      req_ch.semitone <= '0;
      req_ch.octave <= '0;
      req_ch.decays <= 1'b0;
      req_ch.last_note <= 1'b0;

      step_a4 = 32'd39370534;
      beat_len = 24'd48000;
      master_amp = 16'd19661;
      chord_total = 5'd1;
      chord_now = '0;
      beat_left = '0;
      playing = 1'b0;
      active_voices = 0;
      foreach (notes[i]) notes[i] = '0;
      foreach (sizes[i]) sizes[i] = '0;
      foreach (v_phase[i]) begin
         v_phase[i] = '0;
         v_step[i] = '0;
         v_level[i] = '0;
         v_fade[i] = '0;
      end
      for (int k = 0; k < 1024; k++) sine_q15[k] = sine_value(k);

      add_row(make_req(REQ_TICK), 1, 0, 1);
      add_row(make_req(REQ_NONE), 1, 0, 1);
      add_row(make_req(REQ_WRITE, 0, 0, 0, 4, 0, 0), 1, 0, 1);
      add_row(make_req(REQ_WRITE, 0, 1, 11, 8, 1, 0), 1, 0, 1);
      add_row(make_req(REQ_WRITE, 0, 2, 15, 15, 1, 1), 1, 0, 1);
      add_row(make_req(REQ_WRITE, 0, 3, 3, 0, 0, 1), 1, 0, 1);
      add_row(make_req(REQ_START), 1, 0, 0);
      add_row(make_req(REQ_TICK), 1, 0, 0);
      for (int i = 0; i < 6; i++) add_row(make_req(REQ_TICK));
      add_row(make_req(REQ_NONE), 1, 0, 0);
      add_row(make_req(REQ_WRITE, 15, 3, 12, 9, 1, 1), 1, 0, 0);
      add_row(make_req(REQ_WRITE, 0, 3, 2, 5, 1, 1), 1, 0, 0);
      add_row(make_req(REQ_START), 1, 0, 0);
      add_row(make_req(REQ_TICK), 1, 0, 0);
      for (int i = 0; i < 5; i++) add_row(make_req(REQ_TICK));

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[i]) send_item(script[i].item, script[i].typed, script[i].value);

      // fill the whole note table so every chord is defined
      for (int c = 0; c < 16; c++) begin
         pick = $urandom_range(0, 3);
         for (int v = 0; v < 4; v++) begin
            note_req_t it;
            it = random_note(c, v);
            if (v == pick) it.last_note = 1'b1;
            send_item(it);
         end
      end

      while (items_sent < ITEM_TARGET) begin
         quiet = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 2) == 0) begin
            pick = $urandom_range(0, 3);
            csr_write(CSR_STEP_A4, pick == 0 ? 32'd0 : pick == 1 ? 32'hFFFF_FFFF :
                      $urandom());
         end
         if ($urandom_range(0, 2) == 0) begin
            pick = $urandom_range(0, 9);
            csr_write(CSR_BEAT, pick == 0 ? 32'd0 : pick == 1 ? 32'h00FF_FFFF :
                      pick == 2 ? $urandom_range(9, 200) : $urandom_range(1, 8));
         end
         if ($urandom_range(0, 2) == 0) begin
            pick = $urandom_range(0, 3);
            csr_write(CSR_MASTER, pick == 0 ? 32'd0 : pick == 1 ? 32'd65535 :
                      $urandom_range(0, 65535));
         end
         if ($urandom_range(0, 2) == 0) begin
            pick = $urandom_range(0, 5);
            csr_write(CSR_CHORDS, pick == 0 ? 32'd0 : pick == 1 ? 32'd16 :
                      pick == 2 ? $urandom_range(17, 31) : $urandom_range(1, 5));
         end
         for (int i = $urandom_range(0, 4); i > 0; i--)
            send_item(random_note($urandom_range(0, 15), $urandom_range(0, 3)));
         if ($urandom_range(0, 9) < 7) send_item(make_req(REQ_START));
         n_ticks = beat_eff() * chords_eff() + 3;
         if (n_ticks > 80) n_ticks = 80;
         for (int i = 0; i < n_ticks; i++) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) send_item(make_req(REQ_NONE, $urandom_range(0, 15),
                                              $urandom_range(0, 3)));
            else if (pick == 1) send_item(random_note($urandom_range(0, 15),
                                                      $urandom_range(0, 3)));
            else if (pick == 2 && $urandom_range(0, 3) == 0) send_item(make_req(REQ_START));
            else send_item(make_req(REQ_TICK));
         end
      end

      req_ch.valid <= 1'b0;
      while (pending_mix.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("covered %0d items (%0d ticks), %0d results checked, %0d nonzero samples",
               items_sent, ticks_sent, results_seen, nonzero_samples);
      $display("register writes swept step, beat, amplitude and chord count extremes");
      if (mismatches == 0)
         $display("chord_sequencer_sine_voices_core_tb: done, clean");
      else
         $display("chord_sequencer_sine_voices_core_tb: done, errors");
      $finish;
   end

endmodule
